// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the condition, outside reset
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/etx_pkg.sv =====
// shared types, constants and the bytewise crc-32 fold for the ethernet tx tail
// no dependencies
package etx_pkg;

    localparam int COUNT_W          = 11;
    localparam int MIN_BODY_DEFAULT = 60;
    localparam int MAX_BODY_DEFAULT = 1536;
    localparam int MAX_RESULTS      = 64;
    // one body byte and four fcs bytes leave this many for padding
    localparam int PAD_CAP          = MAX_RESULTS - 5;
    localparam int PAD_W            = $clog2(PAD_CAP + 1);
    localparam int LEN_W            = COUNT_W + 1;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_PAD  = 2'd1,
        KIND_FCS  = 2'd2
    } etx_kind_t;

    typedef struct packed {
        logic      too_long;
        logic      frame_end;
        etx_kind_t byte_kind;
        logic [7:0] out_byte;
    } etx_result_t;

    // reflected crc-32, one byte lsb first
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/etx_crc_unit.sv =====
// running crc-32 register with bytewise fold and clear
// depends on etx_pkg
module etx_crc_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fold_en,
    input  logic [7:0]  fold_data,
    input  logic        clear,
    output logic [31:0] crc
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        priority if (clear)
        begin
            crc_next = etx_pkg::CRC_INIT;
        end
        else if (fold_en)
        begin
            crc_next = etx_pkg::crc_fold(crc_reg, fold_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= etx_pkg::CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

// ===== src/etx_out_stage.sv =====
// output register with skid entry; upstream ready comes straight from a flop
// depends on etx_pkg
module etx_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  etx_pkg::etx_result_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output etx_pkg::etx_result_t out_data
);

    logic                 main_valid_reg, main_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    etx_pkg::etx_result_t main_reg, main_next;
    etx_pkg::etx_result_t skid_reg, skid_next;

    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!main_valid_reg || out_ready)
            begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ===== src/ethernet_tx_pad_and_fcs_unit.sv =====
// Ethernet transmit tail: passes frame body bytes, appends zero padding and the
// CRC-32 FCS. One result byte leaves per cycle while m_axis_tready is high. A body
// byte is taken every cycle while the output stage is ready, and is registered there
// before it leaves; after the byte marked tlast the input stalls for the padding bytes
// (none, or enough to bring the body to at least MIN_BODY_BYTES and to a multiple of
// four, at most 59) plus the four FCS bytes. The pace is set by the single bytewise
// CRC fold feeding the output stage. Bodies longer than MAX_BODY_BYTES are passed
// whole but flagged in tuser[2] from the first excess byte to the end of the frame.
// depends on etx_pkg, etx_crc_unit, etx_out_stage, assert_macros.svh
`include "assert_macros.svh"

module ethernet_tx_pad_and_fcs_unit
#(
    parameter int MIN_BODY_BYTES = etx_pkg::MIN_BODY_DEFAULT,
    parameter int MAX_BODY_BYTES = etx_pkg::MAX_BODY_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tlast,   // frame_end
    output logic [2:0] m_axis_tuser    // [1:0] byte_kind, [2] too_long
);

    typedef enum logic [2:0] {
        ST_BODY = 3'b001,
        ST_PAD  = 3'b010,
        ST_FCS  = 3'b100
    } etx_state_t;

    localparam int CW = etx_pkg::COUNT_W;
    localparam int LW = etx_pkg::LEN_W;
    localparam int PW = etx_pkg::PAD_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BODY_BYTES);
    localparam logic [LW-1:0] MIN_LEN   = LW'(MIN_BODY_BYTES);
    localparam logic [LW-1:0] PAD_LIMIT = LW'(etx_pkg::PAD_CAP);

    etx_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          over_reg, over_next;
    logic [PW-1:0] pad_cnt_reg, pad_cnt_next;
    logic [1:0]    fcs_idx_reg, fcs_idx_next;

    logic          stage_ready;
    logic          gen_valid;
    logic          gen_fire;
    logic          in_fire;
    etx_pkg::etx_result_t gen_data;
    etx_pkg::etx_result_t out_data;

    logic          crc_fold_en;
    logic [7:0]    crc_fold_data;
    logic          crc_clear;
    logic [31:0]   crc;
    logic [31:0]   fcs;

    logic [CW-1:0] body_count_new;
    logic          body_over_new;
    logic [LW-1:0] len_min;
    logic [LW-1:0] len_round;
    logic [LW-1:0] pad_full;
    logic [PW-1:0] pad_len;

    assign fcs = ~crc;

    // count and overlong flag after the incoming body byte
    always_comb
    begin
        if (count_reg >= MAX_COUNT)
        begin
            body_count_new = count_reg;
            body_over_new  = 1'b1;
        end
        else
        begin
            body_count_new = count_reg + CW'(1);
            body_over_new  = over_reg;
        end
    end

    // padded length: at least the minimum, rounded up to a multiple of four
    always_comb
    begin
        len_min   = ({1'b0, body_count_new} < MIN_LEN) ? MIN_LEN : {1'b0, body_count_new};
        len_round = ((len_min - LW'(1)) & ~LW'(3)) + LW'(4);
        pad_full  = len_round - {1'b0, body_count_new};
        pad_len   = (pad_full > PAD_LIMIT) ? PW'(etx_pkg::PAD_CAP) : pad_full[PW-1:0];
    end

    assign s_axis_tready = (state_reg == ST_BODY) && stage_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign gen_valid     = (state_reg == ST_BODY) ? s_axis_tvalid : 1'b1;
    assign gen_fire      = gen_valid && stage_ready;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        over_next     = over_reg;
        pad_cnt_next  = pad_cnt_reg;
        fcs_idx_next  = fcs_idx_reg;
        crc_fold_en   = 1'b0;
        crc_fold_data = s_axis_tdata;
        crc_clear     = 1'b0;
        gen_data.out_byte  = s_axis_tdata;
        gen_data.byte_kind = etx_pkg::KIND_DATA;
        gen_data.frame_end = 1'b0;
        gen_data.too_long  = over_reg;

        unique case (state_reg)
            ST_BODY:
            begin
                gen_data.too_long = body_over_new;
                if (in_fire)
                begin
                    crc_fold_en = 1'b1;
                    count_next  = body_count_new;
                    over_next   = body_over_new;
                    if (s_axis_tlast)
                    begin
                        fcs_idx_next = 2'd0;
                        pad_cnt_next = pad_len;
                        state_next   = (pad_len != PW'(0)) ? ST_PAD : ST_FCS;
                    end
                end
            end
            ST_PAD:
            begin
                crc_fold_data      = 8'h00;
                gen_data.out_byte  = 8'h00;
                gen_data.byte_kind = etx_pkg::KIND_PAD;
                if (gen_fire)
                begin
                    crc_fold_en  = 1'b1;
                    pad_cnt_next = pad_cnt_reg - PW'(1);
                    if (pad_cnt_reg == PW'(1))
                    begin
                        state_next = ST_FCS;
                    end
                end
            end
            ST_FCS:
            begin
                gen_data.byte_kind = etx_pkg::KIND_FCS;
                unique case (fcs_idx_reg)
                    2'd0:    gen_data.out_byte = fcs[7:0];
                    2'd1:    gen_data.out_byte = fcs[15:8];
                    2'd2:    gen_data.out_byte = fcs[23:16];
                    default: gen_data.out_byte = fcs[31:24];
                endcase
                gen_data.frame_end = (fcs_idx_reg == 2'd3);
                if (gen_fire)
                begin
                    fcs_idx_next = fcs_idx_reg + 2'd1;
                    if (fcs_idx_reg == 2'd3)
                    begin
                        // frame done: back to reset values
                        crc_clear  = 1'b1;
                        count_next = '0;
                        over_next  = 1'b0;
                        state_next = ST_BODY;
                    end
                end
            end
            default:
            begin
                state_next = ST_BODY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_BODY;
            count_reg   <= '0;
            over_reg    <= 1'b0;
            pad_cnt_reg <= '0;
            fcs_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            over_reg    <= over_next;
            pad_cnt_reg <= pad_cnt_next;
            fcs_idx_reg <= fcs_idx_next;
        end
    end

    etx_crc_unit u_crc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fold_en   (crc_fold_en),
        .fold_data (crc_fold_data),
        .clear     (crc_clear),
        .crc       (crc)
    );

    etx_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gen_valid),
        .in_ready  (stage_ready),
        .in_data   (gen_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = out_data.out_byte;
    assign m_axis_tlast = out_data.frame_end;
    assign m_axis_tuser = {out_data.too_long, out_data.byte_kind};

    `ASSERT_CLK(a_last_is_fcs, !(m_axis_tvalid && m_axis_tlast) || (m_axis_tuser[1:0] == etx_pkg::KIND_FCS), "frame end on a non-fcs transfer")
    `ASSERT_CLK(a_pad_nonzero, (state_reg != ST_PAD) || (pad_cnt_reg != '0), "padding state with nothing left to pad")
    `ASSERT_NEXT(a_frame_reset, gen_fire && (state_reg == ST_FCS) && (fcs_idx_reg == 2'd3), (crc == etx_pkg::CRC_INIT) && (count_reg == '0) && !over_reg && (state_reg == ST_BODY), "frame state not restored after fcs")

endmodule
